>>> rtl/tdcpll_pkg.sv
// Package for the TDC digital PLL loop filter: field widths, register reset values,
// register index codes, filter shift amounts and the constant-divisor reciprocals.
// No dependencies.
`default_nettype none

package tdcpll_pkg;

	// field widths
	localparam int STAMP_W   = 32;
	localparam int TARGET_W  = 31;
	localparam int FLIMIT_W  = 20;
	localparam int ILIMIT_W  = 20;
	localparam int DECIM_W   = 8;
	localparam int INTEG_W   = 21;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// register reset values
	localparam logic [TARGET_W-1:0] TARGET_FREQ_RST = 31'd10000000;
	localparam logic [FLIMIT_W-1:0] FREQ_LIMIT_RST  = 20'd2000;
	localparam logic [ILIMIT_W-1:0] INTEG_LIMIT_RST = 20'd100000;
	localparam logic [STAMP_W-1:0]  PERIOD_MIN_RST  = 32'd1000;
	localparam logic [STAMP_W-1:0]  PERIOD_MAX_RST  = 32'd200000;
	localparam logic [DECIM_W-1:0]  APPLY_DECIM_RST = 8'd16;

	// register index codes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FREQ = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MAX  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_APPLY_DECIM = 3'd5;

	// filter shifts
	localparam int LOWPASS_SHIFT = 7;
	localparam int ACCUM_SHIFT   = 8;

	// x/20 = (x * 0xCCCCCCCD) >> 36, x/100 = (x * 0x51EB851F) >> 37, exact for 32-bit x
	localparam logic [31:0] P_RECIP       = 32'hCCCC_CCCD;
	localparam int          P_RECIP_SHIFT = 36;
	localparam logic [31:0] I_RECIP       = 32'h51EB_851F;
	localparam int          I_RECIP_SHIFT = 37;

	// quotient widths: 2^31/20 < 2^27, 2^21/100 < 2^15
	localparam int QP_W = 27;
	localparam int QI_W = 15;

	// magnitude quotients of the P and I terms, with their signs
	typedef struct packed {
		logic            neg_p;
		logic [QP_W-1:0] q_p;
		logic            neg_i;
		logic [QI_W-1:0] q_i;
	} pi_terms_t;

endpackage

`default_nettype wire

>>> rtl/tdcpll_pi_div.sv
// Truncating division of the filtered error by 20 and the integrator by 100,
// done as reciprocal multiplies on magnitudes. Depends on tdcpll_pkg.
`default_nettype none

module tdcpll_pi_div (
	input  logic signed [31:0]                     err,
	input  logic signed [tdcpll_pkg::INTEG_W-1:0]  integ,
	output tdcpll_pkg::pi_terms_t                  terms
);

	logic [31:0]                    mag_p;
	logic [tdcpll_pkg::INTEG_W-1:0] mag_i;
	logic [63:0]                    prod_p;
	logic [tdcpll_pkg::INTEG_W+31:0] prod_i;

	always_comb begin
		// magnitudes; -2^31 maps to 2^31 as unsigned
		mag_p = err[31] ? (32'd0 - 32'(err)) : 32'(err);
		mag_i = integ[tdcpll_pkg::INTEG_W-1] ?
			(tdcpll_pkg::INTEG_W'(0) - tdcpll_pkg::INTEG_W'(integ)) :
			tdcpll_pkg::INTEG_W'(integ);
		prod_p = 64'(mag_p) * 64'(tdcpll_pkg::P_RECIP);
		prod_i = (tdcpll_pkg::INTEG_W + 32)'(mag_i) *
			(tdcpll_pkg::INTEG_W + 32)'(tdcpll_pkg::I_RECIP);
		terms.neg_p = err[31];
		terms.q_p   = prod_p[tdcpll_pkg::P_RECIP_SHIFT +: tdcpll_pkg::QP_W];
		terms.neg_i = integ[tdcpll_pkg::INTEG_W-1];
		terms.q_i   = prod_i[tdcpll_pkg::I_RECIP_SHIFT +: tdcpll_pkg::QI_W];
	end

endmodule

`default_nettype wire

>>> rtl/tdc_digital_pll_loop_filter_core.sv
// Top level of the TDC digital PLL loop filter: six-stage datapath with config registers.
// Depends on tdcpll_pkg and tdcpll_pi_div.
// An accepted item passes the input register, then the six stages, before out_valid.
// Throughput: one item per cycle while out_stall is low; each piece of loop state is read
// and written in one stage only, so back-to-back edges meet no hazard stalls.
// Reset (arst_n low, asynchronous): pipe empty, loop state zero, freq word and config
// registers at their documented defaults.
`default_nettype none

module tdc_digital_pll_loop_filter_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// edge events
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic [31:0]                           timestamp,
	// results
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [31:0]                    freq_word,
	output logic                                  freq_applied,
	output logic                                  sample_accepted,
	output logic                                  period_rejected,
	output logic signed [31:0]                    phase_delta,
	output logic signed [tdcpll_pkg::INTEG_W-1:0] integral_value,
	output logic signed [31:0]                    filtered_error,
	output logic [31:0]                           dds_edge_count,
	// register writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tdcpll_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tdcpll_pkg::CFG_DAT_W-1:0]      cfg_data
);

	localparam int IW = tdcpll_pkg::INTEG_W;
	localparam logic signed [33:0] FREQ_SAT_MAX = 34'sd2147483647;

	// ---------------- configuration registers ----------------
	logic [tdcpll_pkg::TARGET_W-1:0] target_q;
	logic [tdcpll_pkg::FLIMIT_W-1:0] flim_q;
	logic [tdcpll_pkg::ILIMIT_W-1:0] ilim_q;
	logic [31:0]                     pmin_q;
	logic [31:0]                     pmax_q;
	logic [tdcpll_pkg::DECIM_W-1:0]  decim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= tdcpll_pkg::TARGET_FREQ_RST;
			flim_q   <= tdcpll_pkg::FREQ_LIMIT_RST;
			ilim_q   <= tdcpll_pkg::INTEG_LIMIT_RST;
			pmin_q   <= tdcpll_pkg::PERIOD_MIN_RST;
			pmax_q   <= tdcpll_pkg::PERIOD_MAX_RST;
			decim_q  <= tdcpll_pkg::APPLY_DECIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tdcpll_pkg::CFG_TARGET_FREQ: target_q <= cfg_data[tdcpll_pkg::TARGET_W-1:0];
				tdcpll_pkg::CFG_FREQ_LIMIT:  flim_q   <= cfg_data[tdcpll_pkg::FLIMIT_W-1:0];
				tdcpll_pkg::CFG_INTEG_LIMIT: ilim_q   <= cfg_data[tdcpll_pkg::ILIMIT_W-1:0];
				tdcpll_pkg::CFG_PERIOD_MIN:  pmin_q   <= cfg_data[31:0];
				tdcpll_pkg::CFG_PERIOD_MAX:  pmax_q   <= cfg_data[31:0];
				tdcpll_pkg::CFG_APPLY_DECIM: decim_q  <= cfg_data[tdcpll_pkg::DECIM_W-1:0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	// ---------------- pipe control ----------------
	// vld_q[k] marks stage register k full; stage 7 is the output register.
	// rdy[k]: register k can load this cycle. fire[k]: item leaves register k.
	logic [7:1] vld_q;
	logic [7:1] vld_in;
	logic [8:1] rdy;
	logic [7:1] fire;
	logic [7:1] load;

	assign vld_in = {vld_q[6:1], in_valid};

	always_comb begin
		rdy[8] = !out_stall;
		for (int k = 7; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
		for (int k = 1; k <= 7; k++) begin
			fire[k] = vld_q[k] && rdy[k+1];
			load[k] = rdy[k] && vld_in[k];
		end
	end

	assign in_stall  = !rdy[1];
	assign out_valid = vld_q[7];

	// ---------------- loop state ----------------
	logic [31:0]                    dds_stamp_q;
	logic                           dds_seen_q;
	logic [31:0]                    ref_prev_q;
	logic                           ref_seen_q;
	logic [31:0]                    dds_cnt_q;
	logic signed [31:0]             last_delta_q;
	logic signed [31:0]             ef_q;
	logic [tdcpll_pkg::DECIM_W-1:0] apply_cnt_q;
	logic signed [IW-1:0]           integ_q;
	logic signed [31:0]             freq_q;

	// ---------------- stage registers ----------------
	logic                 mode_s1;
	logic [31:0]          ts_s1;

	logic                 eval_s2;
	logic [31:0]          period_s2;
	logic [31:0]          d_s2;
	logic [31:0]          cnt_s2;

	logic                 acc_s3, rej_s3;
	logic signed [31:0]   delta_s3, ld_s3;
	logic [31:0]          cnt_s3;

	logic                 acc_s4, rej_s4, app_s4;
	logic signed [31:0]   ef_s4, ld_s4;
	logic [31:0]          cnt_s4;

	logic                 rej_s5, acc_s5, app_s5;
	logic signed [31:0]   ef_s5, ld_s5;
	logic signed [IW-1:0] integ_s5;
	logic [31:0]          cnt_s5;

	logic                  rej_s6, acc_s6, app_s6;
	tdcpll_pkg::pi_terms_t terms_s6;
	logic signed [31:0]    ef_s6, ld_s6;
	logic signed [IW-1:0]  integ_s6;
	logic [31:0]           cnt_s6;

	logic signed [31:0]   freq_s7, ld_s7, ef_s7;
	logic                 app_s7, acc_s7, rej_s7;
	logic signed [IW-1:0] integ_s7;
	logic [31:0]          cnt_s7;

	// ---------------- stage A: stamps, period, raw phase ----------------
	// Only a reference edge with both a DDS edge and a prior reference edge behind it
	// is evaluated; every reference edge refreshes the stored stamp.
	logic [31:0] period_a, d_a, cnt_a;
	logic        eval_a;

	always_comb begin
		period_a = ts_s1 - ref_prev_q;
		d_a      = ts_s1 - dds_stamp_q;
		eval_a   = !mode_s1 && dds_seen_q && ref_seen_q;
		cnt_a    = mode_s1 ? (dds_cnt_q + 32'd1) : dds_cnt_q;
	end

	// ---------------- stage B: period window, phase fold ----------------
	logic               rej_b, acc_b, fold_b;
	logic [31:0]        half_b;
	logic signed [31:0] delta_b, ld_b;

	always_comb begin
		rej_b   = eval_s2 && ((period_s2 > pmax_q) || (period_s2 < pmin_q));
		acc_b   = eval_s2 && !rej_b;
		half_b  = {1'b0, period_s2[31:1]};
		// fold once when the phase lead exceeds half a period
		fold_b  = $signed(d_s2) > $signed(half_b);
		delta_b = fold_b ? $signed(d_s2 - period_s2) : $signed(d_s2);
		ld_b    = acc_b ? delta_b : last_delta_q;
	end

	// ---------------- stage C: low-pass, decimation count ----------------
	logic signed [32:0]             diff_c, step_c, f33_c;
	logic signed [31:0]             ef_c;
	logic [tdcpll_pkg::DECIM_W-1:0] cnt_nxt_c;
	logic                           app_c;

	always_comb begin
		// ef += floor((delta - ef) / 2^LOWPASS_SHIFT), arithmetic shift floors
		diff_c    = $signed({delta_s3[31], delta_s3}) - $signed({ef_q[31], ef_q});
		step_c    = diff_c >>> tdcpll_pkg::LOWPASS_SHIFT;
		f33_c     = $signed({ef_q[31], ef_q}) + step_c;
		ef_c      = acc_s3 ? $signed(f33_c[31:0]) : ef_q;
		cnt_nxt_c = apply_cnt_q + tdcpll_pkg::DECIM_W'(1);
		// a decimation of zero, or one lowered below the count, applies at once
		app_c     = acc_s3 && (cnt_nxt_c >= decim_q);
	end

	// ---------------- stage D: clamped integrator ----------------
	logic signed [32:0]   inc_d, sum_d, lim_d, clamp_d;
	logic signed [IW-1:0] integ_d;

	always_comb begin
		inc_d = $signed({ef_s4[31], ef_s4}) >>> tdcpll_pkg::ACCUM_SHIFT;
		sum_d = $signed({{(33-IW){integ_q[IW-1]}}, integ_q}) + inc_d;
		lim_d = $signed({{(33-tdcpll_pkg::ILIMIT_W){1'b0}}, ilim_q});
		if (sum_d > lim_d) begin
			clamp_d = lim_d;
		end else if (sum_d < -lim_d) begin
			clamp_d = -lim_d;
		end else begin
			clamp_d = sum_d;
		end
		integ_d = acc_s4 ? $signed(clamp_d[IW-1:0]) : integ_q;
	end

	// ---------------- stage E: P and I quotients ----------------
	tdcpll_pkg::pi_terms_t terms_e;

	tdcpll_pi_div u_pi_div (
		.err   (ef_s5),
		.integ (integ_s5),
		.terms (terms_e)
	);

	// ---------------- stage F: frequency word ----------------
	// freq = target - ef/20 - integ/100, clamped to target +/- limit and to int32.
	// The low bound is never below -2^20, so only the high bound needs saturating.
	logic signed [33:0] t_f, lim_f, hi_f, lo_f, p_f, i_f, raw_f, clamp_f;
	logic signed [31:0] freq_f;

	always_comb begin
		t_f   = $signed({3'b000, target_q});
		lim_f = $signed({{(34-tdcpll_pkg::FLIMIT_W){1'b0}}, flim_q});
		hi_f  = t_f + lim_f;
		if (hi_f > FREQ_SAT_MAX) begin
			hi_f = FREQ_SAT_MAX;
		end
		lo_f  = t_f - lim_f;
		p_f   = $signed({{(34-tdcpll_pkg::QP_W){1'b0}}, terms_s6.q_p});
		i_f   = $signed({{(34-tdcpll_pkg::QI_W){1'b0}}, terms_s6.q_i});
		if (terms_s6.neg_p) begin
			p_f = -p_f;
		end
		if (terms_s6.neg_i) begin
			i_f = -i_f;
		end
		raw_f = t_f - p_f - i_f;
		if (raw_f > hi_f) begin
			clamp_f = hi_f;
		end else if (raw_f < lo_f) begin
			clamp_f = lo_f;
		end else begin
			clamp_f = raw_f;
		end
		freq_f = app_s6 ? $signed(clamp_f[31:0]) : freq_q;
	end

	// ---------------- control and loop state registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q        <= '0;
			dds_stamp_q  <= '0;
			dds_seen_q   <= 1'b0;
			ref_prev_q   <= '0;
			ref_seen_q   <= 1'b0;
			dds_cnt_q    <= '0;
			last_delta_q <= '0;
			ef_q         <= '0;
			apply_cnt_q  <= '0;
			integ_q      <= '0;
			freq_q       <= $signed({1'b0, tdcpll_pkg::TARGET_FREQ_RST});
		end else begin
			for (int k = 1; k <= 7; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
			if (fire[1]) begin
				if (mode_s1) begin
					dds_stamp_q <= ts_s1;
					dds_seen_q  <= 1'b1;
					dds_cnt_q   <= cnt_a;
				end else begin
					ref_prev_q <= ts_s1;
					ref_seen_q <= 1'b1;
				end
			end
			if (fire[2] && acc_b) begin
				last_delta_q <= delta_b;
			end
			if (fire[3] && acc_s3) begin
				ef_q        <= ef_c;
				apply_cnt_q <= app_c ? '0 : cnt_nxt_c;
			end
			if (fire[4] && acc_s4) begin
				integ_q <= integ_d;
			end
			if (fire[6] && app_s6) begin
				freq_q <= freq_f;
			end
		end
	end

	// ---------------- stage payload registers ----------------
	always_ff @(posedge clk) begin
		if (load[1]) begin
			mode_s1 <= mode;
			ts_s1   <= timestamp;
		end
		if (load[2]) begin
			eval_s2   <= eval_a;
			period_s2 <= period_a;
			d_s2      <= d_a;
			cnt_s2    <= cnt_a;
		end
		if (load[3]) begin
			acc_s3   <= acc_b;
			rej_s3   <= rej_b;
			delta_s3 <= delta_b;
			ld_s3    <= ld_b;
			cnt_s3   <= cnt_s2;
		end
		if (load[4]) begin
			acc_s4 <= acc_s3;
			rej_s4 <= rej_s3;
			app_s4 <= app_c;
			ef_s4  <= ef_c;
			ld_s4  <= ld_s3;
			cnt_s4 <= cnt_s3;
		end
		if (load[5]) begin
			acc_s5   <= acc_s4;
			rej_s5   <= rej_s4;
			app_s5   <= app_s4;
			ef_s5    <= ef_s4;
			integ_s5 <= integ_d;
			ld_s5    <= ld_s4;
			cnt_s5   <= cnt_s4;
		end
		if (load[6]) begin
			acc_s6   <= acc_s5;
			rej_s6   <= rej_s5;
			app_s6   <= app_s5;
			terms_s6 <= terms_e;
			ef_s6    <= ef_s5;
			integ_s6 <= integ_s5;
			ld_s6    <= ld_s5;
			cnt_s6   <= cnt_s5;
		end
		if (load[7]) begin
			freq_s7  <= freq_f;
			app_s7   <= app_s6;
			acc_s7   <= acc_s6;
			rej_s7   <= rej_s6;
			ld_s7    <= ld_s6;
			integ_s7 <= integ_s6;
			ef_s7    <= ef_s6;
			cnt_s7   <= cnt_s6;
		end
	end

	assign freq_word       = freq_s7;
	assign freq_applied    = app_s7;
	assign sample_accepted = acc_s7;
	assign period_rejected = rej_s7;
	assign phase_delta     = ld_s7;
	assign integral_value  = integ_s7;
	assign filtered_error  = ef_s7;
	assign dds_edge_count  = cnt_s7;

	// ---------------- assertions ----------------
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[1])
		else $error("accepted item did not reach the input register");

	a_cnt_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire[3] && app_c) |=> (apply_cnt_q == '0))
		else $error("decimation count not cleared after a word update");

	a_dds_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire[1] && mode_s1) |=> (dds_cnt_q == $past(dds_cnt_q) + 32'd1))
		else $error("DDS edge count did not step");

	a_apply_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!freq_applied || sample_accepted))
		else $error("word update without an accepted sample");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(sample_accepted && period_rejected))
		else $error("sample both accepted and rejected");

endmodule

`default_nettype wire

>>> test/tdcpll_loop_checker.sv
// Scoreboard for the TDC digital PLL loop filter: watches the edge, result and register
// channels, keeps its own copy of the loop state and compares every result item.
// Depends on tdcpll_pkg.
`default_nettype none

module tdcpll_loop_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic                                  mode,
	input  logic [31:0]                           timestamp,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [31:0]                    freq_word,
	input  logic                                  freq_applied,
	input  logic                                  sample_accepted,
	input  logic                                  period_rejected,
	input  logic signed [31:0]                    phase_delta,
	input  logic signed [tdcpll_pkg::INTEG_W-1:0] integral_value,
	input  logic signed [31:0]                    filtered_error,
	input  logic [31:0]                           dds_edge_count,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [tdcpll_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tdcpll_pkg::CFG_DAT_W-1:0]      cfg_data,
	output int                                    fail_count,
	output int                                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tdcpll_pkg::*;

	localparam int     P_DIV       = 20;
	localparam int     I_DIV       = 100;
	localparam longint S32_MAX     = 64'sd2147483647;
	localparam longint S32_MIN     = -64'sd2147483648;
	localparam int     MAX_PRINTED = 40;

	typedef struct packed {
		logic signed [31:0]        freq_word;
		logic                      applied;
		logic                      accepted;
		logic                      rejected;
		logic signed [31:0]        delta;
		logic signed [INTEG_W-1:0] integ;
		logic signed [31:0]        err;
		logic [31:0]               dds_cnt;
	} loop_out_t;

	loop_out_t loop_out_q[$];

	// register copy
	logic [TARGET_W-1:0] target_freq_r;
	logic [FLIMIT_W-1:0] freq_limit_r;
	logic [ILIMIT_W-1:0] integ_limit_r;
	logic [STAMP_W-1:0]  period_min_r;
	logic [STAMP_W-1:0]  period_max_r;
	logic [DECIM_W-1:0]  apply_decim_r;

	// loop state
	logic [31:0]               dds_stamp;
	logic                      dds_seen;
	logic [31:0]               ref_prev;
	logic                      ref_seen;
	logic signed [31:0]        err_filt;
	logic signed [INTEG_W-1:0] integ;
	logic [DECIM_W-1:0]        apply_cnt;
	logic signed [31:0]        freq_cmd;
	logic signed [31:0]        last_delta;
	logic [31:0]               dds_cnt;

	task automatic clear_loop();
		target_freq_r = TARGET_FREQ_RST;
		freq_limit_r  = FREQ_LIMIT_RST;
		integ_limit_r = INTEG_LIMIT_RST;
		period_min_r  = PERIOD_MIN_RST;
		period_max_r  = PERIOD_MAX_RST;
		apply_decim_r = APPLY_DECIM_RST;
		dds_stamp  = '0;
		dds_seen   = 1'b0;
		ref_prev   = '0;
		ref_seen   = 1'b0;
		err_filt   = '0;
		integ      = '0;
		apply_cnt  = '0;
		freq_cmd   = {1'b0, TARGET_FREQ_RST};
		last_delta = '0;
		dds_cnt    = '0;
		loop_out_q.delete();
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		fail_count++;
		if (fail_count <= MAX_PRINTED)
			$display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		case (idx)
			CFG_TARGET_FREQ: target_freq_r = val[TARGET_W-1:0];
			CFG_FREQ_LIMIT:  freq_limit_r  = val[FLIMIT_W-1:0];
			CFG_INTEG_LIMIT: integ_limit_r = val[ILIMIT_W-1:0];
			CFG_PERIOD_MIN:  period_min_r  = val;
			CFG_PERIOD_MAX:  period_max_r  = val;
			CFG_APPLY_DECIM: apply_decim_r = val[DECIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic predict_edge(input logic is_dds, input logic [31:0] ts);
		loop_out_t r;
		logic [31:0] period;
		logic [31:0] d;
		longint f;
		longint acc;
		longint lim;
		longint t;
		longint fw;
		logic applied;
		logic accepted;
		logic rejected;
		applied  = 1'b0;
		accepted = 1'b0;
		rejected = 1'b0;
		if (is_dds) begin
			dds_stamp = ts;
			dds_seen  = 1'b1;
			dds_cnt   = dds_cnt + 32'd1;
		end else begin
			if (dds_seen && ref_seen) begin
				period = ts - ref_prev;
				if (period > period_max_r || period < period_min_r) begin
					rejected = 1'b1;
				end else begin
					// fold once into the half period around the reference edge
					d = ts - dds_stamp;
					if (longint'($signed(d)) > longint'(period >> 1))
						d = d - period;
					last_delta = d;
					f = longint'(err_filt)
						+ ((longint'(last_delta) - longint'(err_filt)) >>> LOWPASS_SHIFT);
					err_filt = f[31:0];
					acc = longint'(integ) + (f >>> ACCUM_SHIFT);
					lim = longint'(integ_limit_r);
					if (acc > lim)
						acc = lim;
					if (acc < -lim)
						acc = -lim;
					integ = acc[INTEG_W-1:0];
					accepted  = 1'b1;
					apply_cnt = apply_cnt + 8'd1;
					if (apply_cnt >= apply_decim_r) begin
						apply_cnt = '0;
						applied   = 1'b1;
						t  = longint'(target_freq_r);
						fw = t - longint'(err_filt) / P_DIV - longint'(integ) / I_DIV;
						if (fw > t + longint'(freq_limit_r))
							fw = t + longint'(freq_limit_r);
						if (fw < t - longint'(freq_limit_r))
							fw = t - longint'(freq_limit_r);
						if (fw > S32_MAX)
							fw = S32_MAX;
						if (fw < S32_MIN)
							fw = S32_MIN;
						freq_cmd = fw[31:0];
					end
				end
			end
			ref_prev = ts;
			if (!rejected)
				ref_seen = 1'b1;
		end
		r.freq_word = freq_cmd;
		r.applied   = applied;
		r.accepted  = accepted;
		r.rejected  = rejected;
		r.delta     = last_delta;
		r.integ     = integ;
		r.err       = err_filt;
		r.dds_cnt   = dds_cnt;
		loop_out_q.push_back(r);
	endtask

	task automatic compare_result();
		loop_out_t w;
		if (loop_out_q.size() == 0) begin
			report_mismatch("result item with nothing predicted", '0, '0);
		end else begin
			w = loop_out_q.pop_front();
			if (freq_word !== w.freq_word)
				report_mismatch("freq_word", freq_word, w.freq_word);
			if (freq_applied !== w.applied)
				report_mismatch("freq_applied", freq_applied, w.applied);
			if (sample_accepted !== w.accepted)
				report_mismatch("sample_accepted", sample_accepted, w.accepted);
			if (period_rejected !== w.rejected)
				report_mismatch("period_rejected", period_rejected, w.rejected);
			if (phase_delta !== w.delta)
				report_mismatch("phase_delta", phase_delta, w.delta);
			if (integral_value !== w.integ)
				report_mismatch("integral_value", integral_value, w.integ);
			if (filtered_error !== w.err)
				report_mismatch("filtered_error", filtered_error, w.err);
			if (dds_edge_count !== w.dds_cnt)
				report_mismatch("dds_edge_count", dds_edge_count, w.dds_cnt);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_loop();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (out_valid && !out_stall)
				compare_result();
			if (cfg_valid && cfg_ready)
				write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				predict_edge(mode, timestamp);
			pending = loop_out_q.size();
		end
	end

endmodule

`default_nettype wire

>>> test/tdc_digital_pll_loop_filter_core_test.sv
// Top of the loop filter testbench: clock, reset, edge and register stimulus, output stall.
// Depends on tdcpll_pkg, tdc_digital_pll_loop_filter_core and tdcpll_loop_checker.
`default_nettype none

module tdc_digital_pll_loop_filter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tdcpll_pkg::*;

	// edge source codes on the mode field
	localparam logic REF_EDGE = 1'b0;
	localparam logic DDS_EDGE = 1'b1;

	// indexes the block decodes to nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	localparam int HOLD_OFF_CYCLES = 300;  // long receiver hold-off, fills the pipe
	localparam int DRAIN_CYCLES    = 20;   // pipe is 7 deep, leave room beyond it
	localparam int WD_LIMIT        = 2000; // cycles with no item moving on any channel

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                                  in_valid = 1'b0;
	logic                                  in_stall;
	logic                                  mode = 1'b0;
	logic [31:0]                           timestamp = '0;
	logic                                  out_valid;
	logic                                  out_stall = 1'b0;
	logic signed [31:0]                    freq_word;
	logic                                  freq_applied;
	logic                                  sample_accepted;
	logic                                  period_rejected;
	logic signed [31:0]                    phase_delta;
	logic signed [INTEG_W-1:0]             integral_value;
	logic signed [31:0]                    filtered_error;
	logic [31:0]                           dds_edge_count;
	logic                                  cfg_valid = 1'b0;
	logic                                  cfg_ready;
	logic [CFG_IDX_W-1:0]                  cfg_index = '0;
	logic [CFG_DAT_W-1:0]                  cfg_data = '0;

	int fail_count;
	int pending;

	// stimulus bookkeeping
	int          edges_sent = 0;
	logic [31:0] ref_t = '0;       // stamp of the last reference edge sent in a sequence
	logic [31:0] cur_pmin = PERIOD_MIN_RST;
	logic [31:0] cur_pmax = PERIOD_MAX_RST;
	logic        tx_calm = 1'b0;   // sender offers back to back
	logic        rx_calm = 1'b0;   // receiver never stalls
	logic        hold_off_req = 1'b0;

	always #1 clk = ~clk;

	tdc_digital_pll_loop_filter_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .timestamp(timestamp),
		.out_valid(out_valid), .out_stall(out_stall),
		.freq_word(freq_word), .freq_applied(freq_applied),
		.sample_accepted(sample_accepted), .period_rejected(period_rejected),
		.phase_delta(phase_delta), .integral_value(integral_value),
		.filtered_error(filtered_error), .dds_edge_count(dds_edge_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tdcpll_loop_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .timestamp(timestamp),
		.out_valid(out_valid), .out_stall(out_stall),
		.freq_word(freq_word), .freq_applied(freq_applied),
		.sample_accepted(sample_accepted), .period_rejected(period_rejected),
		.phase_delta(phase_delta), .integral_value(integral_value),
		.filtered_error(filtered_error), .dds_edge_count(dds_edge_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// Random value in [lo, hi], with the two ends picked often.
	function automatic logic [31:0] pick_in(input logic [31:0] lo, input logic [31:0] hi);
		longint unsigned span;
		span = longint'(hi) - longint'(lo) + 1;
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			default: return lo + 32'({$urandom, $urandom} % span);
		endcase
	endfunction

	// Offer one edge item. Called at a falling edge, returns at the falling edge after
	// it was taken. Valid is only lowered when a gap is wanted, so back to back items
	// see a single assignment per step.
	task automatic send_edge(input logic m, input logic [31:0] ts);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (tx_calm || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		timestamp <= ts;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		edges_sent++;
		@(negedge clk);
	endtask

	// One register write; valid stays up so several writes go back to back.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write all six registers, then drop valid. The period window is remembered so the
	// sequence generator can aim inside or outside it.
	task automatic load_config(input logic [31:0] tgt, input logic [31:0] flim,
			input logic [31:0] ilim, input logic [31:0] pmn, input logic [31:0] pmx,
			input logic [31:0] decim);
		write_reg(CFG_TARGET_FREQ, tgt);
		write_reg(CFG_FREQ_LIMIT, flim);
		write_reg(CFG_INTEG_LIMIT, ilim);
		write_reg(CFG_PERIOD_MIN, pmn);
		write_reg(CFG_PERIOD_MAX, pmx);
		write_reg(CFG_APPLY_DECIM, decim);
		cfg_valid <= 1'b0;
		cur_pmin = pmn;
		cur_pmax = pmx;
	endtask

	// Block is idle once every predicted result has come back: each edge gives one.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// One reference period: mostly a DDS edge somewhere in the period followed by the
	// next reference edge at a period inside the window; some periods fall outside,
	// some lack the DDS edge, and a few edges land at random stamps.
	task automatic send_cycle();
		logic [31:0] per;
		logic [31:0] ph;
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			ph = $urandom;
			if ($urandom_range(0, 1)) begin
				send_edge(DDS_EDGE, ph);
			end else begin
				send_edge(REF_EDGE, ph);
				ref_t = ph;
			end
		end else begin
			if (r < 86 || (cur_pmin == 32'd0 && cur_pmax == 32'hFFFF_FFFF))
				per = pick_in(cur_pmin, cur_pmax);
			else if (cur_pmax != 32'hFFFF_FFFF && (cur_pmin == 32'd0 || $urandom_range(0, 1)))
				per = pick_in(cur_pmax + 32'd1,
					(cur_pmax > 32'hFFFE_FFFF) ? 32'hFFFF_FFFF : cur_pmax + 32'h1_0000);
			else
				per = pick_in((cur_pmin > 32'h1_0000) ? cur_pmin - 32'h1_0000 : 32'd0,
					cur_pmin - 32'd1);
			if ($urandom_range(0, 6) != 0) begin
				case ($urandom_range(0, 2))
					0: ph = $urandom_range(0, 64);         // DDS just after the reference
					1: ph = per - $urandom_range(0, 64);   // DDS just before the next one
					default: ph = pick_in(32'd0, per);
				endcase
				send_edge(DDS_EDGE, ref_t + ph);
				if ($urandom_range(0, 9) == 0)
					send_edge(DDS_EDGE, ref_t + ph + $urandom_range(1, 100));
			end
			ref_t = ref_t + per;
			send_edge(REF_EDGE, ref_t);
		end
	endtask

	task automatic run_random(input int n);
		int stop;
		stop = edges_sent + n;
		while (edges_sent < stop)
			send_cycle();
	endtask

	// Receiver: random stall runs, mostly short, a few long; a requested hold-off is
	// counted here while the sender keeps offering.
	initial begin : receiver
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (rx_calm) begin
				out_stall <= 1'b0;
			end else begin
				n = $urandom_range(0, 9);
				if (n < 5) begin
					out_stall <= 1'b0;
					repeat ($urandom_range(0, 15)) @(negedge clk);
				end else begin
					out_stall <= 1'b1;
					if (n == 9)
						repeat ($urandom_range(10, 40)) @(negedge clk);
					else
						repeat ($urandom_range(0, 2)) @(negedge clk);
				end
			end
		end
	end

	// Watchdog: ends the run if no item moves on any channel for too long.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WD_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed edges on the reset registers (window 1000..200000, decimation 16).
		send_edge(REF_EDGE, 32'd0);            // first reference edge, no DDS yet
		send_edge(REF_EDGE, 32'd5000);         // still no DDS edge: stamp only
		send_edge(DDS_EDGE, 32'hFFFF_FFFF);    // top stamp
		send_edge(REF_EDGE, 32'd10000);        // delta wraps, folded once and still large
		send_edge(DDS_EDGE, 32'd10100);
		send_edge(REF_EDGE, 32'd15000);        // late DDS folds to a small negative delta
		send_edge(REF_EDGE, 32'd15500);        // period below the window
		send_edge(REF_EDGE, 32'd215501);       // period above the window
		send_edge(REF_EDGE, 32'd415501);       // period at the window top
		send_edge(REF_EDGE, 32'd416501);       // period at the window bottom
		send_edge(DDS_EDGE, 32'd416511);
		send_edge(REF_EDGE, 32'd421501);       // DDS just after the reference
		send_edge(DDS_EDGE, 32'hFFFF_F000);
		send_edge(REF_EDGE, 32'hFFFF_FFFF);    // huge period, rejected
		send_edge(DDS_EDGE, 32'hFFFF_FFF0);
		send_edge(REF_EDGE, 32'd4000);         // stamp wraps through zero
		ref_t = 32'd4000;
		wait_idle();

		// Every accepted edge applies, window wide open.
		load_config(TARGET_FREQ_RST, FREQ_LIMIT_RST, INTEG_LIMIT_RST,
			32'd0, 32'hFFFF_FFFF, 32'd1);
		send_edge(DDS_EDGE, ref_t + 32'd3);
		send_edge(REF_EDGE, ref_t + 32'd7);
		send_edge(DDS_EDGE, 32'd0);
		send_edge(REF_EDGE, 32'd0);            // period wraps to near the top, accepted in the open window
		ref_t = 32'd0;
		run_random(56);
		wait_idle();

		// Top target, widest integrator limit and a wide frequency limit: the word saturates; decimation of zero.
		load_config(32'hFFFF_FFFF, 32'd1000000, 32'hFFFF_FFFF, PERIOD_MIN_RST,
			PERIOD_MAX_RST, 32'd0);
		run_random(80);
		wait_idle();

		// Zero target, zero limits, slowest decimation; spare indexes must do nothing.
		write_reg(CFG_SPARE_LO, $urandom);
		write_reg(CFG_SPARE_HI, 32'hFFFF_FFFF);
		load_config(32'd0, 32'd0, 32'd0, 32'd100, 32'd100000, 32'd255);
		run_random(60);
		wait_idle();

		// Decimation dropped below the running count; receiver holds off for a long
		// stretch while the sender keeps pushing, so the pipe fills and stalls input.
		load_config(TARGET_FREQ_RST, 32'd50000, 32'd500000, 32'd100, 32'd100000, 32'd3);
		tx_calm = 1'b1;
		hold_off_req = 1'b1;
		while (hold_off_req)
			@(negedge clk);
		run_random(60);
		tx_calm = 1'b0;
		wait_idle();

		// A stretch with no idling on either side.
		load_config(32'd25000000, 32'd200000, 32'd300000, 32'd500, 32'd50000, 32'd2);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		run_random(80);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		wait_idle();

		// Random register sets.
		for (int k = 0; k < 4; k++) begin
			cur_pmin = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 20000);
			cur_pmax = cur_pmin + $urandom_range(0, 400000);
			load_config($urandom_range(0, 1) ? $urandom : $urandom_range(1000000, 50000000),
				$urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000000),
				$urandom, cur_pmin, cur_pmax, $urandom_range(0, 24));
			run_random(75);
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
